// ===== sv/tfp_pkg.sv =====
package tfp_pkg;

	localparam logic [7:0] SYNC_BYTE     = 8'hAA;
	localparam logic [7:0] TYPE_POWER    = 8'h05;
	localparam logic [7:0] TYPE_STATE    = 8'hF1;
	localparam logic [7:0] POWER_MIN_LEN = 8'd6;
	localparam logic [7:0] STATE_MIN_LEN = 8'd20;
	localparam logic [3:0] POWER_LAST_K  = 4'd1;
	localparam logic [3:0] STATE_LAST_K  = 4'd8;
	localparam logic       KIND_POWER    = 1'b0;
	localparam logic       KIND_STATE    = 1'b1;

	localparam int WORD_COUNT = 9;
	localparam int STORE_TOP  = 2 * WORD_COUNT + 1;

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_TYPE,
		PH_LEN,
		PH_PAYLOAD,
		PH_CHECK
	} tfp_phase_t;

	typedef struct packed {
		logic [7:0]                  id;
		logic                        kind;
		logic [WORD_COUNT-1:0][15:0] words;
	} tfp_frame_t;

endpackage

// ===== sv/tfp_front.sv =====
module tfp_front import tfp_pkg::*; #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [7:0] cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       queue_full,
	output logic       push,
	output tfp_frame_t push_frame
);

	localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

	tfp_phase_t phase_q, phase_d;
	logic [7:0] robot_count_q;
	logic [7:0] type_q;
	logic [7:0] len_q;
	logic [7:0] cnt_q;
	logic [7:0] sum_q;
	logic [7:0] store_q [1:STORE_TOP];
	logic       accept;
	logic       frame_ok;
	logic [7:0] cnt_next;

	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign cnt_next = 8'(cnt_q + 8'd1);

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				PH_HUNT1:   phase_d = (s_tdata == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
				PH_HUNT2:   phase_d = (s_tdata == SYNC_BYTE) ? PH_TYPE : PH_HUNT1;
				PH_TYPE:    phase_d = (s_tdata != SYNC_BYTE) ? PH_LEN : PH_TYPE;
				PH_LEN:     phase_d = (s_tdata == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				PH_PAYLOAD: phase_d = (cnt_next == len_q) ? PH_CHECK : PH_PAYLOAD;
				PH_CHECK:   phase_d = PH_HUNT1;
				default:    phase_d = PH_HUNT1;
			endcase
		end
	end

	always_comb begin
		frame_ok = (s_tdata == sum_q) && ({1'b0, len_q} <= MAX_LEN)
			&& (((type_q == TYPE_POWER) && (len_q >= POWER_MIN_LEN))
			|| ((type_q == TYPE_STATE) && (len_q >= STATE_MIN_LEN)))
			&& (store_q[1] < robot_count_q);
		push = accept && (phase_q == PH_CHECK) && frame_ok;
		push_frame.id   = store_q[1];
		push_frame.kind = (type_q == TYPE_STATE) ? KIND_STATE : KIND_POWER;
		for (int k = 0; k < WORD_COUNT; k++) begin
			push_frame.words[k] = {store_q[2 * k + 2], store_q[2 * k + 3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT1;
			robot_count_q <= 8'd1;
			type_q        <= 8'd0;
			len_q         <= 8'd0;
			cnt_q         <= 8'd0;
			sum_q         <= 8'd0;
		end else begin
			phase_q <= phase_d;
			if (cfg_wen) begin
				robot_count_q <= cfg_wdata;
			end
			if (accept) begin
				case (phase_q)
					PH_TYPE: begin
						if (s_tdata != SYNC_BYTE) begin
							type_q <= s_tdata;
							sum_q  <= 8'(SYNC_BYTE + SYNC_BYTE + s_tdata);
						end
					end
					PH_LEN: begin
						len_q <= s_tdata;
						sum_q <= 8'(sum_q + s_tdata);
						cnt_q <= 8'd0;
					end
					PH_PAYLOAD: begin
						sum_q <= 8'(sum_q + s_tdata);
						cnt_q <= cnt_next;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i <= STORE_TOP; i++) begin
			if (accept && (phase_q == PH_PAYLOAD) && (cnt_q == 8'(i))) begin
				store_q[i] <= s_tdata;
			end
		end
	end

endmodule

// ===== sv/tfp_queue.sv =====
module tfp_queue import tfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tfp_frame_t push_frame,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output tfp_frame_t head_frame
);

	tfp_frame_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= 2'(count_q + 2'd1);
				2'b01:   count_q <= 2'(count_q - 2'd1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

// ===== sv/tfp_back.sv =====
module tfp_back import tfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  tfp_frame_t  head_frame,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	logic [3:0]  k_q;
	logic        valid_q;
	logic [7:0]  id_q;
	logic        kind_q;
	logic [3:0]  index_q;
	logic [16:0] value_q;
	logic        last_q;
	logic        load;
	logic        last_k;
	logic [15:0] word;

	assign load   = head_valid && (!valid_q || m_tready);
	assign last_k = (k_q == ((head_frame.kind == KIND_STATE) ? STATE_LAST_K : POWER_LAST_K));
	assign word   = head_frame.words[k_q];
	assign pop    = load && last_k;

	assign m_tvalid = valid_q;
	assign m_tdata  = {3'd0, value_q, index_q, id_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= 4'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= last_k ? 4'd0 : 4'(k_q + 4'd1);
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q    <= head_frame.id;
			kind_q  <= head_frame.kind;
			index_q <= k_q;
			value_q <= (head_frame.kind == KIND_STATE) ? {word[15], word} : {1'b0, word};
			last_q  <= last_k;
		end
	end

endmodule

// ===== sv/telemetry_frame_parser_unit.sv =====
// Byte-serial telemetry frame parser. One received byte is taken per cycle on the
// s_ side; s_tready drops only while two decoded frames wait undelivered. A frame
// is two 0xAA sync bytes, a type, a length, the payload and an 8-bit sum of the
// two sync bytes, the type, the length and the payload; extra sync bytes before
// the type are skipped and not summed. A good power frame (type 0x05) gives two
// unsigned words, a good
// state frame (type 0xF1) nine sign-extended words, one word per cycle on the m_
// side while m_tready allows, each tagged with the robot id from payload byte 1;
// other frames are swallowed. The checksum byte writes the frame into the queue,
// then its first word is loaded into the output register. A two-frame queue
// splits parser and word emitter, so each stalls on its own; the shortest good
// frame (eleven bytes) outnumbers the longest burst (nine words). cfg_wdata sets
// the robot count when cfg_wen is high; write it only while the block is idle.
module telemetry_frame_parser_unit import tfp_pkg::*; #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // robot_id[7:0], word_index[11:8], word_value[28:12]
	output logic        m_tuser,   // message_kind
	output logic        m_tlast
);

	logic       push;
	logic       full;
	logic       pop;
	logic       head_valid;
	tfp_frame_t push_frame;
	tfp_frame_t head_frame;

	tfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.queue_full(full),
		.push      (push),
		.push_frame(push_frame)
	);

	tfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_frame(push_frame),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_frame(head_frame)
	);

	tfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_frame(head_frame),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/tb_top.sv =====
module tb_top import tfp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 32;

	typedef struct packed {
		logic [7:0]  id;
		logic        kind;
		logic [3:0]  idx;
		logic [16:0] value;
		logic        last;
	} word_rec_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	telemetry_frame_parser_unit #(
		.MAX_PAYLOAD(STORE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// parser state mirrored on the bench side
	tfp_phase_t parse_ph;
	logic [7:0] cur_type;
	logic [7:0] cur_len;
	logic [7:0] byte_cnt;
	logic [7:0] run_sum;
	logic [7:0] payload_mem [STORE_DEPTH];
	logic [7:0] robot_limit;

	word_rec_t  expected_words [$];
	logic [7:0] frame_body [$];
	int         mismatches;
	int         sent_items;
	bit         stall_en;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL telemetry_frame_parser_unit");
		$finish;
	end

	function automatic void close_frame(input logic [7:0] check);
		int         nwords;
		logic       kind;
		logic [7:0] id;
		logic [15:0] w;
		word_rec_t  rec;
		if (check != run_sum || cur_len > STORE_DEPTH)
			return;
		if (cur_type == TYPE_POWER) begin
			nwords = 2;
			kind = KIND_POWER;
			if (cur_len < POWER_MIN_LEN)
				return;
		end else if (cur_type == TYPE_STATE) begin
			nwords = 9;
			kind = KIND_STATE;
			if (cur_len < STATE_MIN_LEN)
				return;
		end else begin
			return;
		end
		id = payload_mem[1];
		if (id >= robot_limit)
			return;
		for (int k = 0; k < nwords; k++) begin
			w = {payload_mem[2*k+2], payload_mem[2*k+3]};
			rec.id = id;
			rec.kind = kind;
			rec.idx = 4'(k);
			rec.value = (kind == KIND_STATE) ? {w[15], w} : {1'b0, w};
			rec.last = (k == nwords - 1);
			expected_words = {expected_words, rec};
		end
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		case (parse_ph)
			PH_HUNT2: begin
				parse_ph = (b == SYNC_BYTE) ? PH_TYPE : PH_HUNT1;
			end
			PH_TYPE: begin
				if (b != SYNC_BYTE) begin
					cur_type = b;
					run_sum = SYNC_BYTE + SYNC_BYTE + b;
					parse_ph = PH_LEN;
				end
			end
			PH_LEN: begin
				cur_len = b;
				run_sum = run_sum + b;
				byte_cnt = 8'd0;
				parse_ph = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (byte_cnt < STORE_DEPTH)
					payload_mem[byte_cnt[4:0]] = b;
				run_sum = run_sum + b;
				byte_cnt = byte_cnt + 8'd1;
				if (byte_cnt == cur_len)
					parse_ph = PH_CHECK;
			end
			PH_CHECK: begin
				close_frame(b);
				parse_ph = PH_HUNT1;
			end
			default: begin
				parse_ph = (b == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	endfunction

	function automatic void check_field(input string fname, input logic [16:0] want,
			input logic [16:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin
		word_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: word expected none got id %h index %h value %h", $time,
					m_tdata[7:0], m_tdata[11:8], m_tdata[28:12]);
			end else begin
				want = expected_words.pop_front();
				check_field("robot_id", want.id, m_tdata[7:0]);
				check_field("word_index", want.idx, m_tdata[11:8]);
				check_field("word_value", want.value, m_tdata[28:12]);
				check_field("message_kind", want.kind, m_tuser);
				check_field("last_word", want.last, m_tlast);
			end
		end
	end

	initial begin
		int n;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_en && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int n;
		if (stall_en && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 11);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		predict_byte(b);
		sent_items++;
	endtask

	task automatic fill_payload(input int len, input logic [7:0] id);
		frame_body = {};
		for (int i = 0; i < len; i++)
			frame_body = {frame_body, 8'($urandom_range(0, 255))};
		if (len > 1)
			frame_body[1] = id;
	endtask

	task automatic send_frame(input logic [7:0] ftype, input int extra_sync, input bit bad_sum);
		logic [7:0] sum;
		sum = SYNC_BYTE + SYNC_BYTE + ftype + 8'(frame_body.size());
		foreach (frame_body[i])
			sum = sum + frame_body[i];
		if (bad_sum)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		repeat (extra_sync) send_byte(SYNC_BYTE);
		send_byte(ftype);
		send_byte(8'(frame_body.size()));
		foreach (frame_body[i])
			send_byte(frame_body[i]);
		send_byte(sum);
	endtask

	// finish any frame still open so the parser is back to hunting
	task automatic flush_parser();
		while (parse_ph != PH_HUNT1)
			send_byte(8'h00);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_robot_count(input logic [7:0] v);
		wait_idle();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		robot_limit = v;
	endtask

	function automatic logic [7:0] good_id();
		if (robot_limit == 8'd0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, robot_limit - 1));
	endfunction

	task automatic test_power_words();
		frame_body = {8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
		send_frame(TYPE_POWER, 0, 1'b0);
		frame_body = {8'h5A, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h11};
		send_frame(TYPE_POWER, 0, 1'b0);
	endtask

	task automatic test_state_words();
		frame_body = {8'h3C, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
			8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h12, 8'h34};
		send_frame(TYPE_STATE, 0, 1'b0);
	endtask

	task automatic test_special_cases();
		// repeated sync before the type
		fill_payload(6, 8'h00);
		send_frame(TYPE_POWER, 3, 1'b0);
		// non-sync byte after the first sync
		send_byte(SYNC_BYTE);
		send_byte(8'h55);
		fill_payload(6, 8'h00);
		send_frame(TYPE_POWER, 0, 1'b0);
		// zero length, other type, bad checksum
		frame_body = {};
		send_frame(TYPE_POWER, 0, 1'b0);
		fill_payload(6, 8'h00);
		send_frame(8'h00, 0, 1'b0);
		fill_payload(20, 8'h00);
		send_frame(TYPE_STATE, 0, 1'b1);
		// too short
		fill_payload(5, 8'h00);
		send_frame(TYPE_POWER, 0, 1'b0);
		fill_payload(19, 8'h00);
		send_frame(TYPE_STATE, 0, 1'b0);
		// id out of range for the reset count
		fill_payload(6, 8'h01);
		send_frame(TYPE_POWER, 0, 1'b0);
	endtask

	task automatic test_long_frames();
		fill_payload(STORE_DEPTH + 1, 8'h00);
		send_frame(TYPE_POWER, 0, 1'b0);
		fill_payload(STORE_DEPTH + 8, 8'h00);
		send_frame(TYPE_STATE, 0, 1'b0);
		fill_payload(STORE_DEPTH, 8'h00);
		send_frame(TYPE_STATE, 0, 1'b0);
	endtask

	task automatic test_robot_count();
		set_robot_count(8'd0);
		fill_payload(6, 8'h00);
		send_frame(TYPE_POWER, 0, 1'b0);
		set_robot_count(8'd255);
		fill_payload(6, 8'd254);
		send_frame(TYPE_POWER, 0, 1'b0);
		fill_payload(6, 8'd255);
		send_frame(TYPE_POWER, 0, 1'b0);
		set_robot_count(8'd17);
		fill_payload(6, 8'd16);
		send_frame(TYPE_POWER, 0, 1'b0);
		fill_payload(6, 8'd17);
		send_frame(TYPE_POWER, 0, 1'b0);
		flush_parser();
	endtask

	task automatic random_frame();
		int         r;
		int         xs;
		logic [7:0] ft;
		r = $urandom_range(0, 99);
		xs = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
		ft = $urandom_range(0, 1) ? TYPE_POWER : TYPE_STATE;
		if (r < 35) begin
			fill_payload($urandom_range(6, 14), good_id());
			send_frame(TYPE_POWER, xs, 1'b0);
		end else if (r < 70) begin
			fill_payload($urandom_range(20, STORE_DEPTH), good_id());
			send_frame(TYPE_STATE, xs, 1'b0);
		end else if (r < 76) begin
			do ft = 8'($urandom_range(0, 255));
			while (ft == SYNC_BYTE);
			fill_payload($urandom_range(0, 24), good_id());
			send_frame(ft, xs, 1'b0);
		end else if (r < 82) begin
			fill_payload((ft == TYPE_POWER) ? 6 : 20, good_id());
			send_frame(ft, xs, 1'b1);
		end else if (r < 87) begin
			fill_payload((ft == TYPE_POWER) ? $urandom_range(0, 5) : $urandom_range(0, 19),
				good_id());
			send_frame(ft, xs, 1'b0);
		end else if (r < 89) begin
			fill_payload($urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8), good_id());
			send_frame(ft, xs, 1'b0);
		end else if (r < 93) begin
			fill_payload((ft == TYPE_POWER) ? 6 : 20, 8'($urandom_range(0, 255)));
			send_frame(ft, xs, 1'b0);
		end else if (r < 97) begin
			repeat ($urandom_range(1, 6))
				send_byte($urandom_range(0, 2) == 0 ? SYNC_BYTE : 8'($urandom_range(0, 255)));
		end else begin
			// header cut short; the next frame gets swallowed as payload
			send_byte(SYNC_BYTE);
			send_byte(SYNC_BYTE);
			send_byte(ft);
			send_byte(8'($urandom_range(1, 12)));
		end
	endtask

	task automatic test_random();
		int start;
		int seg_end;
		int r;
		start = sent_items;
		while (sent_items - start < 40 || stall_en) begin
			seg_end = sent_items + $urandom_range(14, 24);
			stall_en = (sent_items - start < 40) ? ($urandom_range(0, 3) != 0) : 1'b0;
			while (sent_items < seg_end)
				random_frame();
			flush_parser();
			r = $urandom_range(0, 7);
			set_robot_count(r == 0 ? 8'd0 : r == 1 ? 8'd255 : r == 2 ? 8'd1 :
				8'($urandom_range(2, 254)));
		end
		stall_en = 1'b0;
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 8'd0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		parse_ph = PH_HUNT1;
		cur_type = 8'd0;
		cur_len = 8'd0;
		byte_cnt = 8'd0;
		run_sum = 8'd0;
		foreach (payload_mem[i])
			payload_mem[i] = 8'd0;
		robot_limit = 8'd1;
		mismatches = 0;
		sent_items = 0;
		stall_en = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_power_words();
		test_state_words();
		test_special_cases();
		test_long_frames();
		test_robot_count();
		test_random();

		@(negedge clk);
		s_tvalid <= 1'b0;
		guard = 0;
		while (expected_words.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (expected_words.size() != 0) begin
			mismatches++;
			$display("%0t: %0d words expected, none arrived", $time, expected_words.size());
		end
		if (mismatches == 0)
			$display("PASS telemetry_frame_parser_unit");
		else
			$display("FAIL telemetry_frame_parser_unit");
		$finish;
	end

endmodule
